### src/sh24_pkg.sv
// Shared types, constants, microcode table and helpers for the SipHash-2-4 core.
package sh24_pkg;

  // Initialization constants and key reset values.
  localparam logic [63:0] SIP_C0         = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1         = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2         = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3         = 64'h7465646279746573;
  localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
  localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] FINAL_XOR      = 64'h00000000000000ff;

  // Field widths.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned IN_TDATA_W = 72;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_idx_e;

  // Datapath operations driven by the control word.
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_PREP   = 4'd1,
    OP_XV3    = 4'd2,
    OP_HALF_A = 4'd3,
    OP_HALF_B = 4'd4,
    OP_XV0    = 4'd5,
    OP_TAIL   = 4'd6,
    OP_XFF    = 4'd7,
    OP_OUT    = 4'd8
  } op_e;

  // Jump conditions.
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_NOT_LAST = 2'd2,
    COND_NOT_FULL = 2'd3
  } cond_e;

  typedef logic [4:0] pc_t;

  // One control word of the program.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  done;
  } ctrl_word_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic last;
    logic full;
  } sh24_flags_t;

  // Program addresses that are jump targets.
  localparam pc_t PC_START  = 5'd0;
  localparam pc_t PC_XV3    = 5'd1;
  localparam pc_t PC_FINAL  = 5'd9;
  localparam pc_t PC_RETIRE = 5'd19;

  // Microcode program.  Absorbing a block is: XOR into v3, four half
  // rounds, XOR into v0.  Finalization is the 0xff XOR, eight half rounds
  // and the output step.
  function automatic ctrl_word_t sh24_rom(input pc_t pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: COND_NEVER, target: PC_START, done: 1'b0};
    unique case (pc)
      5'd0:  cw.op = OP_PREP;
      5'd1:  cw.op = OP_XV3;
      5'd2:  cw.op = OP_HALF_A;
      5'd3:  cw.op = OP_HALF_B;
      5'd4:  cw.op = OP_HALF_A;
      5'd5:  cw.op = OP_HALF_B;
      5'd6:  begin
        cw.op     = OP_XV0;
        cw.cond   = COND_NOT_LAST;
        cw.target = PC_RETIRE;
      end
      5'd7:  begin
        cw.cond   = COND_NOT_FULL;
        cw.target = PC_FINAL;
      end
      5'd8:  begin
        cw.op     = OP_TAIL;
        cw.cond   = COND_ALWAYS;
        cw.target = PC_XV3;
      end
      5'd9:  cw.op = OP_XFF;
      5'd10: cw.op = OP_HALF_A;
      5'd11: cw.op = OP_HALF_B;
      5'd12: cw.op = OP_HALF_A;
      5'd13: cw.op = OP_HALF_B;
      5'd14: cw.op = OP_HALF_A;
      5'd15: cw.op = OP_HALF_B;
      5'd16: cw.op = OP_HALF_A;
      5'd17: cw.op = OP_HALF_B;
      5'd18: begin
        cw.op   = OP_OUT;
        cw.done = 1'b1;
      end
      5'd19: cw.done = 1'b1;
      default: cw.done = 1'b1;
    endcase
    return cw;
  endfunction

  // Rotate a 64-bit word left by a constant amount.
  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

### src/sh24_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module sh24_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sh24_pkg::sh24_flags_t flags_i,
  input  logic               hold_i,
  output sh24_pkg::op_e      op_o,
  output logic               ready_o
);
  import sh24_pkg::*;

  logic       busy_q, busy_d;
  pc_t        pc_q, pc_d;
  ctrl_word_t cw;
  logic       exec;
  logic       taken;

  // Fetch the current control word; the output step waits on a full output register.
  assign cw    = sh24_rom(pc_q);
  assign exec  = busy_q && !(cw.op == OP_OUT && hold_i);
  assign op_o  = exec ? cw.op : OP_NOP;
  assign ready_o = !busy_q || (exec && cw.done);

  // Evaluate the jump condition.
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NOT_LAST: taken = !flags_i.last;
      COND_NOT_FULL: taken = !flags_i.full;
      default:       taken = 1'b0;
    endcase
  end

  // Next step and busy flag.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (exec) begin
      if (cw.done) begin
        busy_d = 1'b0;
      end else if (taken) begin
        pc_d = cw.target;
      end else begin
        pc_d = pc_q + 5'd1;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = PC_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_START;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

### src/sh24_datapath.sv
// Datapath: four lanes, shared half-round unit, block register and length counter.
module sh24_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           msg_word_i,
  input  logic [3:0]            byte_count_i,
  input  logic                  last_word_i,
  input  logic [63:0]           key_low_i,
  input  logic [63:0]           key_high_i,
  input  sh24_pkg::op_e         op_i,
  output sh24_pkg::sh24_flags_t flags_o,
  output logic [63:0]           hash_o
);
  import sh24_pkg::*;

  logic [63:0] v0_q, v1_q, v2_q, v3_q;
  logic [63:0] v0_d, v1_d, v2_d, v3_d;
  logic [63:0] word_q, m_q, m_d;
  logic [2:0]  cnt_q;
  logic        last_q, full_q, full_d;
  logic        in_msg_q, in_msg_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  len_base;
  logic [7:0]  len_tail;
  logic [63:0] byte_mask;
  logic [63:0] a0, a2;

  assign flags_o = '{last: last_q, full: full_q};
  assign hash_o  = v0_q ^ v1_q ^ v2_q ^ v3_q;

  // Length at the start of this item and the length including a short tail.
  assign len_base = in_msg_q ? len_q : 8'd0;
  assign len_tail = len_base + {5'd0, cnt_q};

  // Keep the bytes below the valid count.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = (i < int'(cnt_q)) ? 8'hff : 8'h00;
    end
  end

  // Operation decode.
  always_comb begin
    v0_d     = v0_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    v3_d     = v3_q;
    m_d      = m_q;
    full_d   = full_q;
    in_msg_d = in_msg_q;
    len_d    = len_q;
    a0       = '0;
    a2       = '0;
    unique case (op_i)
      OP_NOP: ;
      OP_PREP: begin
        if (!in_msg_q) begin
          v0_d = SIP_C0 ^ key_low_i;
          v1_d = SIP_C1 ^ key_high_i;
          v2_d = SIP_C2 ^ key_low_i;
          v3_d = SIP_C3 ^ key_high_i;
        end
        in_msg_d = 1'b1;
        if (full_q) begin
          len_d = len_base + 8'd8;
          m_d   = word_q;
        end else begin
          len_d = len_tail;
          m_d   = {len_tail, 56'd0} | (word_q & byte_mask);
        end
      end
      OP_XV3: v3_d = v3_q ^ m_q;
      OP_HALF_A: begin
        a0   = v0_q + v1_q;
        a2   = v2_q + v3_q;
        v1_d = rotl64(v1_q, 13) ^ a0;
        v0_d = rotl64(a0, 32);
        v3_d = rotl64(v3_q, 16) ^ a2;
        v2_d = a2;
      end
      OP_HALF_B: begin
        a0   = v0_q + v3_q;
        a2   = v2_q + v1_q;
        v3_d = rotl64(v3_q, 21) ^ a0;
        v0_d = a0;
        v1_d = rotl64(v1_q, 17) ^ a2;
        v2_d = rotl64(a2, 32);
      end
      OP_XV0: v0_d = v0_q ^ m_q;
      // A last item of eight bytes is followed by a tail of only the length.
      OP_TAIL: begin
        m_d    = {len_q, 56'd0};
        full_d = 1'b0;
      end
      OP_XFF: v2_d = v2_q ^ FINAL_XOR;
      OP_OUT: in_msg_d = 1'b0;
      default: ;
    endcase
    if (start_i) begin
      full_d = !last_word_i || (byte_count_i >= 4'd8);
    end
  end

  // Control and length state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      len_q    <= '0;
      full_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
      len_q    <= len_d;
      full_q   <= full_d;
      if (start_i) begin
        last_q <= last_word_i;
      end
    end
  end

  // Lanes and captured item.
  always_ff @(posedge clk_i) begin
    v0_q <= v0_d;
    v1_q <= v1_d;
    v2_q <= v2_d;
    v3_q <= v3_d;
    m_q  <= m_d;
    if (start_i) begin
      word_q <= msg_word_i;
      cnt_q  <= byte_count_i[2:0];
    end
  end

endmodule

### src/siphash_2_4.sv
// Top level of the SipHash-2-4 core: stream ports, key registers, output register.
// A full message word is absorbed before the next item is accepted, and a last item runs
// through finalization to its hash (with an extra length-only block when it holds eight
// bytes), set by the microcode sequencer driving one shared half-round unit per cycle.
// The output register lets the next message start while a hash waits to be taken.
// Reset (rst_ni low, asynchronous) clears control state and loads the default key.
module siphash_2_4 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [63:0] msg_word, [67:64] byte_count, zero pad
  input  logic        s_axis_tlast_i,  // last_word
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [63:0] hash_value
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import sh24_pkg::*;

  logic [63:0]  key_low_q, key_high_q;
  logic         out_valid_q;
  logic [63:0]  out_data_q;
  logic         start;
  op_e          op;
  sh24_flags_t  flags;
  logic [63:0]  hash;
  logic         in_ready;

  assign s_axis_tready_o = in_ready;
  assign start           = s_axis_tvalid_i && in_ready;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= KEY_LOW_RESET;
      key_high_q <= KEY_HIGH_RESET;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sh24_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .hold_i  (out_valid_q && !m_axis_tready_i),
    .op_o    (op),
    .ready_o (in_ready)
  );

  sh24_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .msg_word_i   (s_axis_tdata_i[63:0]),
    .byte_count_i (s_axis_tdata_i[67:64]),
    .last_word_i  (s_axis_tlast_i),
    .key_low_i    (key_low_q),
    .key_high_i   (key_high_q),
    .op_i         (op),
    .flags_o      (flags),
    .hash_o       (hash)
  );

  // Output register: loaded by the output step, cleared when the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_OUT) begin
      out_data_q <= hash;
    end
  end

endmodule

### tb/tb_siphash_2_4.sv
// Self-checking testbench for the siphash_2_4 stream core with a hash predictor.
module tb_siphash_2_4;
  timeunit 1ns;
  timeprecision 1ps;

  import sh24_pkg::*;

  // Cycles of quiet after the last hash before the block counts as idle.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int PHASE_ITEMS   = 130;

  // Predicts SipHash-2-4 results and checks the hashes that come out.
  class hash_scoreboard;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] lane0, lane1, lane2, lane3;
    logic [7:0]  msg_len;
    bit          msg_open;
    logic [63:0] hash_q[$];
    int          mismatches;
    int          hashes_checked;

    function new();
      key_lo         = KEY_LOW_RESET;
      key_hi         = KEY_HIGH_RESET;
      lane0          = '0;
      lane1          = '0;
      lane2          = '0;
      lane3          = '0;
      msg_len        = '0;
      msg_open       = 1'b0;
      mismatches     = 0;
      hashes_checked = 0;
    endfunction

    function automatic logic [63:0] rol(logic [63:0] x, int unsigned r);
      logic [127:0] both;
      both = {x, x} << r;
      return both[127:64];
    endfunction

    function void sip_round();
      lane0 = lane0 + lane1;
      lane1 = rol(lane1, 13) ^ lane0;
      lane0 = rol(lane0, 32);
      lane2 = lane2 + lane3;
      lane3 = rol(lane3, 16) ^ lane2;
      lane0 = lane0 + lane3;
      lane3 = rol(lane3, 21) ^ lane0;
      lane2 = lane2 + lane1;
      lane1 = rol(lane1, 17) ^ lane2;
      lane2 = rol(lane2, 32);
    endfunction

    // One compression: mix the block into v3, two rounds, mix into v0.
    function void absorb(logic [63:0] blk);
      lane3 = lane3 ^ blk;
      sip_round();
      sip_round();
      lane0 = lane0 ^ blk;
    endfunction

    function void write_key(reg_idx_e idx, logic [63:0] value);
      if (idx == REG_KEY_LOW) begin
        key_lo = value;
      end else begin
        key_hi = value;
      end
    endfunction

    function int pending();
      return hash_q.size();
    endfunction

    // Called for every accepted input item; queues a hash on the last one.
    function void note_word(logic [63:0] word, logic [3:0] count, logic last);
      logic [63:0] tail;
      int unsigned n;
      n = (count > 4'd8) ? 8 : count;
      // The key is only sampled when a message opens.
      if (!msg_open) begin
        lane0    = SIP_C0 ^ key_lo;
        lane1    = SIP_C1 ^ key_hi;
        lane2    = SIP_C2 ^ key_lo;
        lane3    = SIP_C3 ^ key_hi;
        msg_len  = '0;
        msg_open = 1'b1;
      end
      // Non-last words and an eight-byte last word are full blocks.
      if (!last || n == 8) begin
        absorb(word);
        msg_len = msg_len + 8'd8;
        if (!last) begin
          return;
        end
        n = 0;
      end
      msg_len = msg_len + 8'(n);
      tail = {msg_len, 56'h0};
      if (n > 0) begin
        tail = tail | (word & ((64'h1 << (8 * n)) - 64'h1));
      end
      absorb(tail);
      lane2 = lane2 ^ FINAL_XOR;
      repeat (4) sip_round();
      hash_q.push_back(lane0 ^ lane1 ^ lane2 ^ lane3);
      msg_open = 1'b0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Called for every accepted result item.
    task check_hash(logic [63:0] got);
      logic [63:0] want;
      if (hash_q.size() == 0) begin
        report($sformatf("hash %h arrived with no message pending", got));
      end else begin
        want = hash_q.pop_front();
        hashes_checked++;
        if (got !== want) begin
          report($sformatf("hash_value got %h expected %h", got, want));
        end
      end
    endtask
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i     = '0;
  logic [63:0] cfg_data_i      = '0;

  hash_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int msgs_sent     = 0;
  int keys_set      = 0;
  int quiet_cycles  = 0;

  siphash_2_4 i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random backpressure at the current pressure level.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch all three channels and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_word(s_axis_tdata_i[63:0], s_axis_tdata_i[67:64], s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_hash(m_axis_tdata_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_key(reg_idx_e'(cfg_index_i), cfg_data_i);
      end
    end
  end

  // Hang detection: nothing accepted anywhere for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("ERROR: no item accepted for %0d cycles", HANG_LIMIT);
      $display("siphash_2_4 verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return '1;
    end
    return {$urandom(), $urandom()};
  endfunction

  // Offer one message word; returns at the edge where it is accepted.
  task automatic push_word(input logic [63:0] word, input logic [3:0] count,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'h0, count, word};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (last) begin
      msgs_sent++;
    end
  endtask

  // Leaves valid high so a following write needs no second assignment.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    cfg_valid_i <= 1'b0;
    keys_set++;
  endtask

  // Stop offering items, wait for every predicted hash, then let the core run quiet.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly short messages, some medium, a few long enough to wrap the length byte.
  task automatic send_random_message();
    int pick;
    int n_full;
    logic [3:0] count;
    pick = $urandom_range(99);
    if (pick < 85) begin
      n_full = $urandom_range(4);
    end else if (pick < 95) begin
      n_full = $urandom_range(12, 5);
    end else begin
      n_full = $urandom_range(40, 30);
    end
    for (int i = 0; i < n_full; i++) begin
      push_word(rand_word(), 4'($urandom_range(15)), 1'b0);
    end
    if ($urandom_range(9) < 7) begin
      count = 4'($urandom_range(8));
    end else begin
      count = 4'($urandom_range(15, 9));
    end
    push_word(rand_word(), count, 1'b1);
  endtask

  task automatic run_traffic(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_random_message();
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct,
                           input logic [63:0] lo_a, input logic [63:0] hi_a,
                           input logic [63:0] lo_b, input logic [63:0] hi_b);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    settle();
    set_key(lo_a, hi_a);
    run_traffic(PHASE_ITEMS);
    settle();
    set_key(lo_b, hi_b);
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages under the reset key.
    send_idle_pct = 16;
    recv_idle_pct = 82;
    push_word(rand_word(), 4'd0, 1'b1);          // empty message
    push_word('1, 4'd8, 1'b1);                   // eight bytes on the last item
    push_word('0, 4'd15, 1'b1);                  // count above eight saturates
    push_word('1, 4'd9, 1'b1);
    push_word('1, 4'd1, 1'b1);                   // bytes past the count ignored
    push_word('0, 4'd0, 1'b0);
    push_word('1, 4'd7, 1'b1);
    push_word(rand_word(), 4'd3, 1'b0);          // count ignored on non-last words
    push_word(rand_word(), 4'd4, 1'b1);
    push_word('1, 4'd15, 1'b0);
    push_word('0, 4'd8, 1'b0);
    push_word(rand_word(), 4'd8, 1'b1);
    push_word(rand_word(), 4'd2, 1'b1);
    push_word(rand_word(), 4'd5, 1'b1);
    push_word(rand_word(), 4'd6, 1'b1);
    push_word(rand_word(), 4'd12, 1'b1);

    // Random traffic in three pressure profiles, two keys each.
    run_phase(16, 82, '0, '0, rand_word(), '1);
    run_phase(82, 16, '1, '0, {$urandom(), $urandom()}, {$urandom(), $urandom()});
    run_phase(0, 0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
              KEY_LOW_RESET, KEY_HIGH_RESET);

    settle();
    $display("Sent %0d items in %0d messages over %0d key settings and three pressure profiles.",
             items_sent, msgs_sent, keys_set + 1);
    $display("Checked %0d hashes, %0d mismatches.", sb.hashes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("siphash_2_4 verification clean");
    end else begin
      $display("siphash_2_4 verification failed");
    end
    $finish;
  end

endmodule
